>>> sv/frm_pkg.sv
// Package for the rolling frame-rate meter.
// Holds shared widths, constants, controller states, command/status structs and clamp.
// No dependencies.
package frm_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int WL_W       = 11;
    localparam int TS_W       = 48;
    localparam int IV_W       = 32;
    localparam int SUM_W      = IV_W + ADDR_W;
    localparam int RATE_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int US_W       = 20;
    localparam int PROD_W     = CNT_W + US_W;
    localparam int NUM_W      = PROD_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int CLAMP_W    = (WL_W > CNT_W) ? WL_W : CNT_W;

    localparam logic [US_W-1:0] US_PER_S   = US_W'(1000000);
    localparam logic [WL_W-1:0] WL_RESET   = WL_W'(15);
    localparam int              MIN_WINDOW = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_SUB,
        S_ADD,
        S_DIV_INIT,
        S_DIV,
        S_DONE,
        S_SWEEP
    } t_state;

    typedef struct packed {
        logic load_item;
        logic cfg_write;
        logic delta;
        logic sub;
        logic add;
        logic div_init;
        logic div_step;
        logic load_out;
        logic sweep;
    } t_cmd;

    typedef struct packed {
        logic shrink;
        logic sweep_done;
        logic div_done;
        logic out_free;
    } t_status;

    function automatic logic [CNT_W-1:0] clamp_window(input logic [WL_W-1:0] w);
        logic [CLAMP_W-1:0] wx;
        wx = CLAMP_W'(w);
        if (wx < CLAMP_W'(MIN_WINDOW)) begin
            return CNT_W'(MIN_WINDOW);
        end
        if (wx > CLAMP_W'(MAX_WINDOW)) begin
            return CNT_W'(MAX_WINDOW);
        end
        return CNT_W'(wx);
    endfunction

endpackage

>>> sv/frm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/frm_ctrl.sv
// Controller state machine for the rolling frame-rate meter.
// Depends on frm_pkg; drives frm_dp through t_cmd, reads t_status.
module frm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  frm_pkg::t_status i_status,
    output frm_pkg::t_cmd    o_cmd
);

    frm_pkg::t_state r_state;
    frm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            frm_pkg::S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_ready     = !i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.cfg_write = 1'b1;
                    if (i_status.shrink) begin
                        n_state = frm_pkg::S_SWEEP;
                    end
                end else if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = frm_pkg::S_DELTA;
                end
            end
            frm_pkg::S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state     = frm_pkg::S_SUB;
            end
            frm_pkg::S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = frm_pkg::S_ADD;
            end
            frm_pkg::S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = frm_pkg::S_DIV_INIT;
            end
            frm_pkg::S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = frm_pkg::S_DIV;
            end
            frm_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    n_state = frm_pkg::S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            frm_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = frm_pkg::S_IDLE;
                end
            end
            frm_pkg::S_SWEEP: begin
                if (i_status.sweep_done) begin
                    n_state = frm_pkg::S_IDLE;
                end else begin
                    o_cmd.sweep = 1'b1;
                end
            end
            default: begin
                n_state = frm_pkg::S_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == frm_pkg::S_DELTA))
        else $error("accepted transaction did not start the update");

    a_cfg_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != frm_pkg::S_IDLE) |-> (!o_ready && !o_cfg_ready))
        else $error("ready raised while busy");

endmodule

>>> sv/frm_dp.sv
// Datapath for the rolling frame-rate meter: interval ring, running sum,
// window resize sweep, bit-serial divider and output register.
// Depends on frm_pkg and frm_ram.
module frm_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  frm_pkg::t_cmd                i_cmd,
    output frm_pkg::t_status             o_status,
    input  logic                         i_tick,
    input  logic [frm_pkg::TS_W-1:0]     i_timestamp_us,
    input  logic                         i_clear,
    input  logic [frm_pkg::WL_W-1:0]     i_cfg_window_length,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [frm_pkg::RATE_W-1:0]   o_rate_q16,
    output logic                         o_empty_res
);

    // control state
    logic [frm_pkg::CNT_W-1:0]     r_cap, n_cap;
    logic [frm_pkg::CNT_W-1:0]     r_wp, n_wp;
    logic [frm_pkg::CNT_W-1:0]     r_count, n_count;
    logic [frm_pkg::SUM_W-1:0]     r_sum, n_sum;
    logic [frm_pkg::TS_W-1:0]      r_prev_time, n_prev_time;
    logic                          r_prev_valid, n_prev_valid;
    logic [frm_pkg::CNT_W-1:0]     r_sw_idx, n_sw_idx;
    logic                          r_sw_pend, n_sw_pend;
    logic [frm_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                          r_out_valid, n_out_valid;

    // payload
    logic                          r_tick, n_tick;
    logic [frm_pkg::TS_W-1:0]      r_ts, n_ts;
    logic                          r_clear, n_clear;
    logic [frm_pkg::IV_W-1:0]      r_iv, n_iv;
    logic [frm_pkg::ADDR_W-1:0]    r_slot, n_slot;
    logic                          r_hit, n_hit;
    logic [frm_pkg::NUM_W-1:0]     r_num, n_num;
    logic [frm_pkg::SUM_W-1:0]     r_rem, n_rem;
    logic [frm_pkg::RATE_W-1:0]    r_quo, n_quo;
    logic                          r_ovf, n_ovf;
    logic [frm_pkg::RATE_W-1:0]    r_rate, n_rate;
    logic                          r_empty, n_empty;

    // combinational helpers
    logic [frm_pkg::CNT_W-1:0]     cap_new;
    logic [frm_pkg::ADDR_W-1:0]    slot_c;
    logic [frm_pkg::CNT_W-1:0]     slot_p1;
    logic [frm_pkg::TS_W-1:0]      diff;
    logic [frm_pkg::IV_W-1:0]      iv_c;
    logic                          store_c;
    logic [frm_pkg::PROD_W-1:0]    prod;
    logic [frm_pkg::SUM_W:0]       trial;
    logic [frm_pkg::SUM_W:0]       trial_sub;
    logic                          q_bit;
    logic                          empty_c;

    // memory port
    logic                          ram_we;
    logic [frm_pkg::ADDR_W-1:0]    ram_raddr;
    logic [frm_pkg::IV_W-1:0]      ram_rdata;

    frm_ram #(
        .WIDTH (frm_pkg::IV_W),
        .DEPTH (frm_pkg::MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_iv),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cap_new = frm_pkg::clamp_window(i_cfg_window_length);
    assign slot_c  = (r_wp == r_cap) ? '0 : r_wp[frm_pkg::ADDR_W-1:0];
    assign slot_p1 = {1'b0, r_slot} + frm_pkg::CNT_W'(1);
    assign diff    = r_ts - r_prev_time;
    assign store_c = r_tick && r_prev_valid;
    assign prod    = frm_pkg::PROD_W'(r_count) * frm_pkg::PROD_W'(frm_pkg::US_PER_S);
    assign trial   = {r_rem, r_num[frm_pkg::NUM_W-1]};
    assign trial_sub = trial - {1'b0, r_sum};
    assign q_bit   = (trial >= {1'b0, r_sum});
    assign empty_c = (r_count == '0);

    always_comb begin
        if (r_ts < r_prev_time) begin
            iv_c = '0;
        end else if (|diff[frm_pkg::TS_W-1:frm_pkg::IV_W]) begin
            iv_c = '1;
        end else begin
            iv_c = diff[frm_pkg::IV_W-1:0];
        end
    end

    assign o_status.shrink     = (cap_new < r_cap);
    assign o_status.sweep_done = (r_sw_idx >= r_count) && !r_sw_pend && (r_wp < r_cap);
    assign o_status.div_done   = (r_div_cnt == frm_pkg::DIV_CNT_W'(frm_pkg::NUM_W));
    assign o_status.out_free   = !r_out_valid || i_ready;

    always_comb begin
        n_cap        = r_cap;
        n_wp         = r_wp;
        n_count      = r_count;
        n_sum        = r_sum;
        n_prev_time  = r_prev_time;
        n_prev_valid = r_prev_valid;
        n_sw_idx     = r_sw_idx;
        n_sw_pend    = r_sw_pend;
        n_div_cnt    = r_div_cnt;
        n_out_valid  = r_out_valid;
        n_tick       = r_tick;
        n_ts         = r_ts;
        n_clear      = r_clear;
        n_iv         = r_iv;
        n_slot       = r_slot;
        n_hit        = r_hit;
        n_num        = r_num;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_ovf        = r_ovf;
        n_rate       = r_rate;
        n_empty      = r_empty;
        ram_we       = 1'b0;
        ram_raddr    = slot_c;

        if (i_cmd.cfg_write) begin
            if (cap_new > r_cap) begin
                n_cap = cap_new;
                n_wp  = r_count;
            end else if (cap_new < r_cap) begin
                n_cap     = cap_new;
                n_sum     = '0;
                n_sw_idx  = '0;
                n_sw_pend = 1'b0;
                if (r_count > cap_new) begin
                    n_count = cap_new;
                end
            end
        end

        if (i_cmd.load_item) begin
            n_tick  = i_tick;
            n_ts    = i_timestamp_us;
            n_clear = i_clear;
        end

        if (i_cmd.delta) begin
            n_iv   = iv_c;
            n_slot = slot_c;
            n_hit  = ({1'b0, slot_c} < r_count);
        end

        if (i_cmd.sub && store_c && r_hit) begin
            n_sum = r_sum - frm_pkg::SUM_W'(ram_rdata);
        end

        if (i_cmd.add) begin
            if (store_c) begin
                ram_we = 1'b1;
                n_sum  = r_sum + frm_pkg::SUM_W'(r_iv);
                n_wp   = slot_p1;
                if (r_count < slot_p1) begin
                    n_count = slot_p1;
                end
            end
            if (r_tick) begin
                n_prev_time  = r_ts;
                n_prev_valid = 1'b1;
            end
            // clear takes effect after the tick
            if (r_clear) begin
                n_wp         = '0;
                n_count      = '0;
                n_sum        = '0;
                n_prev_time  = '0;
                n_prev_valid = 1'b0;
            end
        end

        if (i_cmd.sweep) begin
            ram_raddr = r_sw_idx[frm_pkg::ADDR_W-1:0];
            n_sw_pend = (r_sw_idx < r_count);
            if (r_sw_idx < r_count) begin
                n_sw_idx = r_sw_idx + frm_pkg::CNT_W'(1);
            end
            if (r_sw_pend) begin
                n_sum = r_sum + frm_pkg::SUM_W'(ram_rdata);
            end
            if (r_wp >= r_cap) begin
                n_wp = r_wp - r_cap;
            end
        end

        if (i_cmd.div_init) begin
            n_num     = {prod, {frm_pkg::FRAC_W{1'b0}}};
            n_rem     = '0;
            n_quo     = '0;
            n_ovf     = 1'b0;
            n_div_cnt = '0;
        end

        // restoring division, one quotient bit per cycle
        if (i_cmd.div_step) begin
            n_num     = {r_num[frm_pkg::NUM_W-2:0], 1'b0};
            n_rem     = q_bit ? trial_sub[frm_pkg::SUM_W-1:0] : trial[frm_pkg::SUM_W-1:0];
            n_quo     = {r_quo[frm_pkg::RATE_W-2:0], q_bit};
            n_ovf     = r_ovf || r_quo[frm_pkg::RATE_W-1];
            n_div_cnt = r_div_cnt + frm_pkg::DIV_CNT_W'(1);
        end

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
            n_empty     = empty_c;
            n_rate      = (empty_c || (r_sum == '0) || r_ovf) ? '1 : r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= frm_pkg::clamp_window(frm_pkg::WL_RESET);
            r_wp         <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_prev_time  <= '0;
            r_prev_valid <= 1'b0;
            r_sw_idx     <= '0;
            r_sw_pend    <= 1'b0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cap        <= n_cap;
            r_wp         <= n_wp;
            r_count      <= n_count;
            r_sum        <= n_sum;
            r_prev_time  <= n_prev_time;
            r_prev_valid <= n_prev_valid;
            r_sw_idx     <= n_sw_idx;
            r_sw_pend    <= n_sw_pend;
            r_div_cnt    <= n_div_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick  <= n_tick;
        r_ts    <= n_ts;
        r_clear <= n_clear;
        r_iv    <= n_iv;
        r_slot  <= n_slot;
        r_hit   <= n_hit;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_ovf   <= n_ovf;
        r_rate  <= n_rate;
        r_empty <= n_empty;
    end

    assign o_valid     = r_out_valid;
    assign o_rate_q16  = r_rate;
    assign o_empty_res = r_empty;

    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("stored count exceeds window");

    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cap >= frm_pkg::CNT_W'(frm_pkg::MIN_WINDOW))
        && (r_cap <= frm_pkg::CNT_W'(frm_pkg::MAX_WINDOW)))
        else $error("window out of range");

    a_wp_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.sweep |-> (r_wp <= r_cap))
        else $error("write position beyond window outside resize");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_ready))
        else $error("pending result overwritten");

endmodule

>>> sv/frame_rate_rolling_meter.sv
// Rolling frame-rate meter. One result per input transaction: the mean event
// rate over the last window_length intervals, unsigned Q16.16, saturated, with
// an empty flag. A transaction runs from acceptance through the states DELTA,
// SUB and ADD, which update the interval ring and running sum through the
// registered-read interval RAM, then DIV_INIT and DIV, the bit-serial restoring
// divider (47 quotient bits, one per cycle), and DONE, which hands off to the
// output register once it is free. No new transaction is accepted before
// then. A configuration write that shrinks the window starts a resize sweep
// through the stored intervals to rebuild the sum and wrap the write position;
// no transaction is accepted while it runs.
// Other configuration writes start no sweep.
// Depends on frm_pkg, frm_ctrl, frm_dp, frm_ram.
module frame_rate_rolling_meter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_tick,
    input  logic [frm_pkg::TS_W-1:0]     i_timestamp_us,
    input  logic                         i_clear,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [frm_pkg::RATE_W-1:0]   o_rate_q16,
    output logic                         o_empty_res,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [frm_pkg::WL_W-1:0]     i_cfg_window_length
);

    frm_pkg::t_cmd    cmd;
    frm_pkg::t_status status;

    frm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    frm_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_tick              (i_tick),
        .i_timestamp_us      (i_timestamp_us),
        .i_clear             (i_clear),
        .i_cfg_window_length (i_cfg_window_length),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_rate_q16          (o_rate_q16),
        .o_empty_res         (o_empty_res)
    );

endmodule
